// ===== rtl/core/bxgcd_pkg.sv =====
// Package for the binary extended GCD block: widths, microcode encoding and program.
package bxgcd_pkg;

    // Operand width; bits of the input words above it are ignored.
    localparam int OPERAND_WIDTH = 62;
    localparam int OPERAND_W     = OPERAND_WIDTH;
    // Coefficients carry two bits of headroom for the add-before-halve step.
    localparam int COEFF_W       = OPERAND_W + 2;
    localparam int SHIFT_W       = $clog2(OPERAND_W);
    // Fixed field widths of the result word.
    localparam int GCD_W         = 62;
    localparam int COEFF_OUT_W   = 63;
    localparam int IN_DATA_W     = 128;
    localparam int OUT_DATA_W    = 192;

    // Step counter of the sequencer.
    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT      = 4'd0;
    localparam step_t STEP_ZERO_CHK  = 4'd1;
    localparam step_t STEP_STRIP_TWO = 4'd2;
    localparam step_t STEP_INIT      = 4'd3;
    localparam step_t STEP_HALVE_U   = 4'd4;
    localparam step_t STEP_HALVE_V   = 4'd5;
    localparam step_t STEP_SUB       = 4'd6;
    localparam step_t STEP_LOOP      = 4'd7;
    localparam step_t STEP_FIN_NORM  = 4'd8;
    localparam step_t STEP_FIN_SPEC  = 4'd9;
    localparam step_t STEP_LAST      = STEP_FIN_SPEC;

    // Condition that selects between the two targets of a step.
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_START,
        COND_ANY_ZERO,
        COND_BOTH_EVEN,
        COND_U_EVEN,
        COND_V_EVEN,
        COND_U_NZ,
        COND_OUT_FREE
    } cond_t;

    // Datapath operation, carried out only when the condition holds.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_SHIFT_BOTH,
        OP_INIT,
        OP_HALVE_U,
        OP_HALVE_V,
        OP_SUB,
        OP_FIN_NORM,
        OP_FIN_SPEC
    } op_t;

    // One control word of the program.
    typedef struct packed {
        cond_t cond;
        op_t   op;
        step_t tgt_true;
        step_t tgt_false;
    } ctrl_word_t;

    // Status flags returned by the datapath.
    typedef struct packed {
        logic start;
        logic any_zero;
        logic both_even;
        logic u_even;
        logic v_even;
        logic u_nz;
        logic out_free;
    } dp_flags_t;

    // Program store: one control word per step.
    function automatic ctrl_word_t program_word(input step_t step);
        ctrl_word_t w;
        unique case (step)
            STEP_WAIT:      w = '{COND_START,     OP_LOAD,       STEP_ZERO_CHK,  STEP_WAIT};
            STEP_ZERO_CHK:  w = '{COND_ANY_ZERO,  OP_NOP,        STEP_FIN_SPEC,  STEP_STRIP_TWO};
            STEP_STRIP_TWO: w = '{COND_BOTH_EVEN, OP_SHIFT_BOTH, STEP_STRIP_TWO, STEP_INIT};
            STEP_INIT:      w = '{COND_ALWAYS,    OP_INIT,       STEP_HALVE_U,   STEP_HALVE_U};
            STEP_HALVE_U:   w = '{COND_U_EVEN,    OP_HALVE_U,    STEP_HALVE_U,   STEP_HALVE_V};
            STEP_HALVE_V:   w = '{COND_V_EVEN,    OP_HALVE_V,    STEP_HALVE_V,   STEP_SUB};
            STEP_SUB:       w = '{COND_ALWAYS,    OP_SUB,        STEP_LOOP,      STEP_LOOP};
            STEP_LOOP:      w = '{COND_U_NZ,      OP_NOP,        STEP_HALVE_U,   STEP_FIN_NORM};
            STEP_FIN_NORM:  w = '{COND_OUT_FREE,  OP_FIN_NORM,   STEP_WAIT,      STEP_FIN_NORM};
            STEP_FIN_SPEC:  w = '{COND_OUT_FREE,  OP_FIN_SPEC,   STEP_WAIT,      STEP_FIN_SPEC};
            default:        w = '{COND_ALWAYS,    OP_NOP,        STEP_WAIT,      STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/bxgcd_seq.sv =====
// Microcode sequencer: step counter, program store and condition select.
module bxgcd_seq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bxgcd_pkg::dp_flags_t  flags,
    output bxgcd_pkg::op_t        op,
    output logic                  accept_ready
);
    import bxgcd_pkg::*;

    step_t      step_reg;
    step_t      step_next;
    ctrl_word_t word;
    logic       cond_true;

    // Fetch the control word of the current step.
    assign word = program_word(step_reg);

    // Evaluate the condition named by the control word.
    always_comb begin
        unique case (word.cond)
            COND_ALWAYS:    cond_true = 1'b1;
            COND_START:     cond_true = flags.start;
            COND_ANY_ZERO:  cond_true = flags.any_zero;
            COND_BOTH_EVEN: cond_true = flags.both_even;
            COND_U_EVEN:    cond_true = flags.u_even;
            COND_V_EVEN:    cond_true = flags.v_even;
            COND_U_NZ:      cond_true = flags.u_nz;
            COND_OUT_FREE:  cond_true = flags.out_free;
            default:        cond_true = 1'b0;
        endcase
    end

    // Issue the operation and choose the next step.
    assign op           = cond_true ? word.op : OP_NOP;
    assign step_next    = cond_true ? word.tgt_true : word.tgt_false;
    assign accept_ready = (word.cond == COND_START);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

    // The step counter never leaves the program.
    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_LAST)
        else $error("step counter outside the program");

    // Only the waiting step takes a new word.
    a_ready_only_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_ready |-> step_reg == STEP_WAIT)
        else $error("input ready outside the waiting step");

endmodule

// ===== rtl/core/bxgcd_datapath.sv =====
// Datapath: operand, magnitude and coefficient registers plus the result register.
module bxgcd_datapath (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  bxgcd_pkg::op_t                           op,
    input  logic                                     in_valid,
    input  logic [bxgcd_pkg::OPERAND_W-1:0]          in_a,
    input  logic [bxgcd_pkg::OPERAND_W-1:0]          in_b,
    output bxgcd_pkg::dp_flags_t                     flags,
    input  logic                                     out_ready,
    output logic                                     out_valid,
    output logic [bxgcd_pkg::GCD_W-1:0]              out_gcd,
    output logic signed [bxgcd_pkg::COEFF_OUT_W-1:0] out_x,
    output logic signed [bxgcd_pkg::COEFF_OUT_W-1:0] out_y
);
    import bxgcd_pkg::*;

    typedef logic signed [COEFF_W-1:0] coeff_t;

    logic [OPERAND_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [OPERAND_W-1:0] u_reg, u_next, v_reg, v_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;
    coeff_t               ca_reg, ca_next, cb_reg, cb_next;
    coeff_t               cc_reg, cc_next, cd_reg, cd_next;
    logic [GCD_W-1:0]     gcd_reg, gcd_next;
    coeff_t               x_reg, x_next, y_reg, y_next;
    logic                 res_valid_reg, res_valid_next;

    logic [OPERAND_W:0]   diff_uv;
    logic [OPERAND_W-1:0] diff_vu;
    coeff_t               ra, rb;
    coeff_t               hp_u, hq_u, hp_v, hq_v;

    // Halve the first coefficient of a pair, adding the reduced b when needed.
    function automatic coeff_t halve_p(input coeff_t p, input coeff_t q, input coeff_t rbv);
        coeff_t s;
        s = ((p[0] | q[0]) == 1'b0) ? p : (p + rbv);
        return s >>> 1;
    endfunction

    // Halve the second coefficient of a pair, subtracting the reduced a when needed.
    function automatic coeff_t halve_q(input coeff_t p, input coeff_t q, input coeff_t rav);
        coeff_t s;
        s = ((p[0] | q[0]) == 1'b0) ? q : (q - rav);
        return s >>> 1;
    endfunction

    assign ra = signed'({2'b00, a_reg});
    assign rb = signed'({2'b00, b_reg});

    // Shared arithmetic for the halving and subtraction steps.
    assign hp_u    = halve_p(ca_reg, cb_reg, rb);
    assign hq_u    = halve_q(ca_reg, cb_reg, ra);
    assign hp_v    = halve_p(cc_reg, cd_reg, rb);
    assign hq_v    = halve_q(cc_reg, cd_reg, ra);
    assign diff_uv = {1'b0, u_reg} - {1'b0, v_reg};
    assign diff_vu = v_reg - u_reg;

    // Status flags for the sequencer.
    assign flags.start     = in_valid;
    assign flags.any_zero  = (a_reg == '0) || (b_reg == '0);
    assign flags.both_even = !(a_reg[0] | b_reg[0]);
    assign flags.u_even    = !u_reg[0];
    assign flags.v_even    = !v_reg[0];
    assign flags.u_nz      = (u_reg != '0);
    assign flags.out_free  = !res_valid_reg || out_ready;

    // Next values according to the issued operation.
    always_comb begin
        a_next         = a_reg;
        b_next         = b_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        shift_next     = shift_reg;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        cc_next        = cc_reg;
        cd_next        = cd_reg;
        gcd_next       = gcd_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        res_valid_next = res_valid_reg && !out_ready;
        unique case (op)
            OP_NOP: begin
            end
            OP_LOAD: begin
                a_next     = in_a;
                b_next     = in_b;
                shift_next = '0;
            end
            OP_SHIFT_BOTH: begin
                a_next     = a_reg >> 1;
                b_next     = b_reg >> 1;
                shift_next = shift_reg + 1'b1;
            end
            OP_INIT: begin
                u_next  = a_reg;
                v_next  = b_reg;
                ca_next = coeff_t'(1);
                cb_next = '0;
                cc_next = '0;
                cd_next = coeff_t'(1);
            end
            OP_HALVE_U: begin
                u_next  = u_reg >> 1;
                ca_next = hp_u;
                cb_next = hq_u;
            end
            OP_HALVE_V: begin
                v_next  = v_reg >> 1;
                cc_next = hp_v;
                cd_next = hq_v;
            end
            OP_SUB: begin
                if (!diff_uv[OPERAND_W]) begin
                    u_next  = diff_uv[OPERAND_W-1:0];
                    ca_next = ca_reg - cc_reg;
                    cb_next = cb_reg - cd_reg;
                end else begin
                    v_next  = diff_vu;
                    cc_next = cc_reg - ca_reg;
                    cd_next = cd_reg - cb_reg;
                end
            end
            OP_FIN_NORM: begin
                gcd_next       = GCD_W'(v_reg) << shift_reg;
                x_next         = cc_reg;
                y_next         = cd_reg;
                res_valid_next = 1'b1;
            end
            OP_FIN_SPEC: begin
                if (b_reg == '0) begin
                    gcd_next = GCD_W'(a_reg);
                    x_next   = coeff_t'(1);
                    y_next   = '0;
                end else begin
                    gcd_next = GCD_W'(b_reg);
                    x_next   = '0;
                    y_next   = coeff_t'(1);
                end
                res_valid_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
        a_reg     <= a_next;
        b_reg     <= b_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        shift_reg <= shift_next;
        ca_reg    <= ca_next;
        cb_reg    <= cb_next;
        cc_reg    <= cc_next;
        cd_reg    <= cd_next;
        gcd_reg   <= gcd_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
    end

    // Result word.
    assign out_valid = res_valid_reg;
    assign out_gcd   = gcd_reg;
    assign out_x     = COEFF_OUT_W'(x_reg);
    assign out_y     = COEFF_OUT_W'(y_reg);

    // The coefficient loop starts with at least one odd reduced operand.
    a_init_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        op == OP_INIT |-> (a_reg[0] | b_reg[0]))
        else $error("loop started with both reduced operands even");

    // Halving is only issued on an even magnitude.
    a_halve_even: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_HALVE_U |-> !u_reg[0]) and (op == OP_HALVE_V |-> !v_reg[0]))
        else $error("halving issued on an odd magnitude");

    // The normal finish only follows a loop that reached zero.
    a_fin_u_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        op == OP_FIN_NORM |-> u_reg == '0)
        else $error("result taken before the loop finished");

    // A held result is never overwritten.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == OP_FIN_NORM || op == OP_FIN_SPEC) |-> (!res_valid_reg || out_ready))
        else $error("result register overwritten while held");

endmodule

// ===== rtl/core/binary_extended_gcd.sv =====
// Top level of the binary extended GCD block: stream ports, sequencer and datapath.
//
//  Channel | Direction | Word contents (lowest bit first)
//  s_      | in        | operand_a[61:0], operand_b[123:62], zero pad [127:124]
//  m_      | out       | gcd_value[61:0], coeff_x[124:62], coeff_y[187:125], zero pad
//
// One word at a time. With an operand of zero a word goes from the zero check straight
// to the special finish step. Otherwise the shared factors of two are stripped first,
// and then the microcode loop over one shared shift/subtract datapath halves u and v
// and subtracts the smaller from the larger until u reaches zero. The result waits in
// an output register; a stalled m_ side holds the program at its final step. Reset
// returns the step counter to the waiting step and clears the result valid flag.
module binary_extended_gcd (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // operand_a [61:0], operand_b [123:62]
    input  logic [bxgcd_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // gcd_value [61:0], coeff_x [124:62], coeff_y [187:125]
    output logic [bxgcd_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import bxgcd_pkg::*;

    op_t                          op;
    dp_flags_t                    flags;
    logic [GCD_W-1:0]             gcd_value;
    logic signed [COEFF_OUT_W-1:0] coeff_x;
    logic signed [COEFF_OUT_W-1:0] coeff_y;

    bxgcd_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .flags        (flags),
        .op           (op),
        .accept_ready (s_tready)
    );

    // Operand bits above the configured width are dropped here.
    bxgcd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .in_valid  (s_tvalid),
        .in_a      (s_tdata[OPERAND_W-1:0]),
        .in_b      (s_tdata[GCD_W +: OPERAND_W]),
        .flags     (flags),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_gcd   (gcd_value),
        .out_x     (coeff_x),
        .out_y     (coeff_y)
    );

    // Pack the result word.
    assign m_tdata = {{(OUT_DATA_W - GCD_W - 2*COEFF_OUT_W){1'b0}}, coeff_y, coeff_x, gcd_value};

endmodule
